// File: src/sma_pkg.sv
// ----------------------------------------------------------------------------
// Six-axis moving average: shared definitions
// Channel count, configuration register indexes and the control group
// that passes from the front end to the back end.
// ----------------------------------------------------------------------------
package sma_pkg;

  localparam int unsigned CHANNELS       = 6;
  localparam int unsigned CH_W           = 3;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned CFG_DATA_W     = 7;
  localparam int unsigned DEFAULT_LENGTH = 10;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLED        = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HISTORY_LENGTH = 1'b1;

  localparam logic [CH_W-1:0] FIRST_CHANNEL = 3'd0;
  localparam logic [CH_W-1:0] LAST_CHANNEL  = 3'd5;

  // Head of the front-end queue as seen by the back end
  typedef struct packed {
    logic valid;  // an item waits in the queue
    logic take;   // the item's sample goes into the ring
  } item_ctrl_t;

endpackage

// File: src/six_axis_moving_average.sv
// ----------------------------------------------------------------------------
// Six-axis moving average
// Boxcar filter over three force and three torque channels in signed
// Q16.16, with a sample ring, running sums and truncating averages.
// ----------------------------------------------------------------------------
// Every input beat returns one output beat with the six window averages
// (channel sum / history_length, truncated toward zero). A beat's sample
// enters the ring only while enabled is set and tuser (step rejected) is
// low. Items are processed one at a time by the back end: a taken sample
// goes through the ring and sum update (read, write and accumulate states
// per channel); for every item the shared bit-serial divider then divides
// each of the six SUM_W-bit sums in turn, one quotient bit at a time, where
// SUM_W = SAMPLE_WIDTH + log2(MAX_DEPTH). A two-beat input queue and the
// output register let both sides stall independently. Writing a non-zero
// history_length while disabled clears the ring and the sums at once; no
// clearing pass is needed and the block is ready after reset.
module six_axis_moving_average #(
  parameter int unsigned MAX_DEPTH    = 64,
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [sma_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [sma_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // force_x, force_y, force_z, torque_x, torque_y, torque_z, zero pad
  input  logic [((sma_pkg::CHANNELS*SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // step_rejected
  input  logic                                 s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // avg_force_x, avg_force_y, avg_force_z, avg_torque_x, avg_torque_y,
  // avg_torque_z, zero pad
  output logic [((sma_pkg::CHANNELS*SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned DATA_W  = sma_pkg::CHANNELS * SAMPLE_WIDTH;
  localparam int unsigned TDATA_W = ((DATA_W + 7) / 8) * 8;
  localparam int unsigned LEN_W   = $clog2(MAX_DEPTH + 1);
  localparam int unsigned CMP_W   =
    (LEN_W > sma_pkg::CFG_DATA_W) ? LEN_W : sma_pkg::CFG_DATA_W;
  localparam logic [LEN_W-1:0] RESET_LEN =
    (sma_pkg::DEFAULT_LENGTH > MAX_DEPTH) ? LEN_W'(1) : LEN_W'(sma_pkg::DEFAULT_LENGTH);

  logic                 enabled_q;
  logic [LEN_W-1:0]     len_q;
  logic [CMP_W-1:0]     wr_len;
  logic [LEN_W-1:0]     wr_len_sat;
  logic                 len_write;
  logic                 clear;

  sma_pkg::item_ctrl_t  item;
  logic [DATA_W-1:0]    item_samples;
  logic                 item_pop;
  logic [DATA_W-1:0]    avg;

  // Length writes count only while disabled and non-zero; saturate at depth
  assign wr_len     = CMP_W'(cfg_wdata_i);
  assign wr_len_sat = (wr_len > CMP_W'(MAX_DEPTH)) ? LEN_W'(MAX_DEPTH) : LEN_W'(wr_len);
  assign len_write  = cfg_we_i && (cfg_idx_i == sma_pkg::REG_HISTORY_LENGTH);
  assign clear      = len_write && !enabled_q && (cfg_wdata_i != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
      len_q     <= RESET_LEN;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sma_pkg::REG_ENABLED: begin
          enabled_q <= cfg_wdata_i[0];
        end
        sma_pkg::REG_HISTORY_LENGTH: begin
          if (clear) begin
            len_q <= wr_len_sat;
          end
        end
        default: begin
        end
      endcase
    end
  end

  sma_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .TDATA_W      (TDATA_W)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .enabled_i     (enabled_q),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .pop_i         (item_pop),
    .item_o        (item),
    .samples_o     (item_samples)
  );

  sma_back #(
    .MAX_DEPTH    (MAX_DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clear_i       (clear),
    .len_i         (len_q),
    .item_i        (item),
    .samples_i     (item_samples),
    .pop_o         (item_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .avg_o         (avg)
  );

  assign m_axis_tdata = TDATA_W'(avg);

endmodule

// File: src/sma_front.sv
// ----------------------------------------------------------------------------
// Six-axis moving average: front end
// Accepts input beats, decides whether the sample is taken into the ring
// and holds the item in a two-entry queue until the back end pops it.
// ----------------------------------------------------------------------------
module sma_front #(
  parameter int unsigned SAMPLE_WIDTH = 32,
  parameter int unsigned TDATA_W      = 192
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       enabled_i,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  input  logic [TDATA_W-1:0]                         s_axis_tdata,
  input  logic                                       s_axis_tuser,
  input  logic                                       pop_i,
  output sma_pkg::item_ctrl_t                        item_o,
  output logic [sma_pkg::CHANNELS*SAMPLE_WIDTH-1:0]  samples_o
);

  localparam int unsigned DATA_W = sma_pkg::CHANNELS * SAMPLE_WIDTH;

  logic [1:0]        count_q, count_d;
  logic              wr_ptr_q, wr_ptr_d;
  logic              rd_ptr_q, rd_ptr_d;
  logic              take_q [2];
  logic [DATA_W-1:0] data_q [2];
  logic              push;
  logic              pop;

  assign s_axis_tready = (count_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = pop_i && (count_q != 2'd0);

  always_comb begin
    count_d  = count_q;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  // A sample counts only while powered and when the step is not rejected
  always_ff @(posedge clk_i) begin
    if (push) begin
      take_q[wr_ptr_q] <= enabled_i && !s_axis_tuser;
      data_q[wr_ptr_q] <= s_axis_tdata[DATA_W-1:0];
    end
  end

  assign item_o.valid = (count_q != 2'd0);
  assign item_o.take  = take_q[rd_ptr_q];
  assign samples_o    = data_q[rd_ptr_q];

endmodule

// File: src/sma_div.sv
// ----------------------------------------------------------------------------
// Six-axis moving average: divider
// Restoring division of a signed channel sum by the window length, one
// quotient bit per cycle, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module sma_div #(
  parameter int unsigned SUM_W = 38,
  parameter int unsigned LEN_W = 7,
  parameter int unsigned Q_W   = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] dividend_i,
  input  logic [LEN_W-1:0] divisor_i,
  output logic             done_o,
  output logic [Q_W-1:0]   quotient_o
);

  localparam int unsigned CNT_W = $clog2(SUM_W);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [SUM_W-1:0] num_q;
  logic [LEN_W-1:0] rem_q;
  logic [LEN_W-1:0] den_q;
  logic             neg_q;
  logic [SUM_W-1:0] dividend_abs;
  logic [LEN_W:0]   trial;
  logic [LEN_W:0]   diff;
  logic             ge;
  logic [SUM_W-1:0] num_neg;

  assign dividend_abs = dividend_i[SUM_W-1] ? ('0 - dividend_i) : dividend_i;
  assign trial        = {rem_q, num_q[SUM_W-1]};
  assign diff         = trial - {1'b0, den_q};
  assign ge           = (trial >= {1'b0, den_q});
  assign num_neg      = '0 - num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(SUM_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Shift the magnitude left; quotient bits fill in from the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_abs;
      rem_q <= '0;
      den_q <= divisor_i;
      neg_q <= dividend_i[SUM_W-1];
    end else if (busy_q) begin
      num_q <= {num_q[SUM_W-2:0], ge};
      rem_q <= ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? num_neg[Q_W-1:0] : num_q[Q_W-1:0];

endmodule

// File: src/sma_back.sv
// ----------------------------------------------------------------------------
// Six-axis moving average: back end
// Pops classified items, updates the sample ring and the six running sums
// channel by channel for taken samples, divides each sum by the window
// length and holds the averages in the output register.
// ----------------------------------------------------------------------------
module sma_back #(
  parameter int unsigned MAX_DEPTH    = 64,
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input  logic                                                      clk_i,
  input  logic                                                      rst_ni,
  input  logic                                                      clear_i,
  input  logic [$clog2(MAX_DEPTH+1)-1:0]                            len_i,
  input  sma_pkg::item_ctrl_t                                       item_i,
  input  logic [sma_pkg::CHANNELS*SAMPLE_WIDTH-1:0]                 samples_i,
  output logic                                                      pop_o,
  output logic                                                      m_axis_tvalid,
  input  logic                                                      m_axis_tready,
  output logic [sma_pkg::CHANNELS*SAMPLE_WIDTH-1:0]                 avg_o
);

  localparam int unsigned SW      = SAMPLE_WIDTH;
  localparam int unsigned CH      = sma_pkg::CHANNELS;
  localparam int unsigned CH_W    = sma_pkg::CH_W;
  localparam int unsigned DEPTH   = MAX_DEPTH * CH;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned LEN_W   = $clog2(MAX_DEPTH + 1);
  localparam int unsigned POS_W   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int unsigned SUM_W   = SW + ((MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1);
  localparam int unsigned DELTA_W = SW + 1;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_RD        = 3'd1;
  localparam logic [2:0] S_WR        = 3'd2;
  localparam logic [2:0] S_ACC       = 3'd3;
  localparam logic [2:0] S_DIV_START = 3'd4;
  localparam logic [2:0] S_DIV_WAIT  = 3'd5;
  localparam logic [2:0] S_OUT       = 3'd6;

  logic [2:0]                state_q, state_d;
  logic [CH_W-1:0]           ch_q, ch_d;
  logic [POS_W-1:0]          pos_q, pos_d;
  logic                      wrapped_q, wrapped_d;
  logic signed [SUM_W-1:0]   sum_q [CH];
  logic                      out_valid_q, out_valid_d;

  logic [SW-1:0]             samples_q [CH];
  logic [SW-1:0]             rd_q;
  logic signed [DELTA_W-1:0] delta_q;
  logic [SW-1:0]             res_q [CH];
  logic [CH*SW-1:0]          out_data_q;
  logic [SW-1:0]             ring_mem [DEPTH];

  logic [ADDR_W-1:0]         addr;
  logic [SW-1:0]             new_sample;
  logic [SW-1:0]             old_sample;
  logic [LEN_W-1:0]          pos_inc;
  logic                      last_ch;
  logic                      out_load;
  logic                      div_start;
  logic                      div_done;
  logic [SW-1:0]             div_quot;

  assign addr       = ADDR_W'(pos_q * CH + ch_q);
  assign new_sample = samples_q[ch_q];
  // Entries not yet reached since the last clear read as zero
  assign old_sample = wrapped_q ? rd_q : '0;
  assign pos_inc    = LEN_W'(pos_q) + LEN_W'(1);
  assign last_ch    = (ch_q == sma_pkg::LAST_CHANNEL);
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || m_axis_tready);
  assign div_start  = (state_q == S_DIV_START);
  assign pop_o      = (state_q == S_IDLE) && item_i.valid;

  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    pos_d       = pos_q;
    wrapped_d   = wrapped_q;
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        ch_d = sma_pkg::FIRST_CHANNEL;
        if (item_i.valid) begin
          state_d = item_i.take ? S_RD : S_DIV_START;
        end
      end
      S_RD: begin
        state_d = S_WR;
      end
      S_WR: begin
        state_d = S_ACC;
      end
      S_ACC: begin
        if (last_ch) begin
          ch_d    = sma_pkg::FIRST_CHANNEL;
          state_d = S_DIV_START;
          if (pos_inc == len_i) begin
            pos_d     = '0;
            wrapped_d = 1'b1;
          end else begin
            pos_d = POS_W'(pos_inc);
          end
        end else begin
          ch_d    = ch_q + CH_W'(1);
          state_d = S_RD;
        end
      end
      S_DIV_START: begin
        state_d = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          if (last_ch) begin
            state_d = S_OUT;
          end else begin
            ch_d    = ch_q + CH_W'(1);
            state_d = S_DIV_START;
          end
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (clear_i) begin
      pos_d     = '0;
      wrapped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ch_q        <= sma_pkg::FIRST_CHANNEL;
      pos_q       <= '0;
      wrapped_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < CH; c++) begin
        sum_q[c] <= '0;
      end
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      pos_q       <= pos_d;
      wrapped_q   <= wrapped_d;
      out_valid_q <= out_valid_d;
      if (clear_i) begin
        for (int c = 0; c < CH; c++) begin
          sum_q[c] <= '0;
        end
      end else if (state_q == S_ACC) begin
        sum_q[ch_q] <= sum_q[ch_q] + SUM_W'(delta_q);
      end
    end
  end

  // Sample ring: read in S_RD, overwrite the same entry in S_WR
  always_ff @(posedge clk_i) begin
    if (state_q == S_RD) begin
      rd_q <= ring_mem[addr];
    end
    if (state_q == S_WR) begin
      ring_mem[addr] <= new_sample;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      for (int c = 0; c < CH; c++) begin
        samples_q[c] <= samples_i[c*SW +: SW];
      end
    end
    if (state_q == S_WR) begin
      delta_q <= $signed({new_sample[SW-1], new_sample})
               - $signed({old_sample[SW-1], old_sample});
    end
    if ((state_q == S_DIV_WAIT) && div_done) begin
      res_q[ch_q] <= div_quot;
    end
    if (out_load) begin
      for (int c = 0; c < CH; c++) begin
        out_data_q[c*SW +: SW] <= res_q[c];
      end
    end
  end

  sma_div #(
    .SUM_W (SUM_W),
    .LEN_W (LEN_W),
    .Q_W   (SW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q[ch_q]),
    .divisor_i  (len_i),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign m_axis_tvalid = out_valid_q;
  assign avg_o         = out_data_q;

`ifndef SYNTH
  a_pos_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LEN_W'(pos_q) < len_i)
    else $error("ring position outside the window");

  a_wrap_from_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(wrapped_q) |-> $past(state_q) == S_ACC)
    else $error("ring wrapped outside a sum update");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV_WAIT)
    else $error("divider finished while not awaited");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_valid_q && !m_axis_tready) |=> state_q == S_OUT)
    else $error("result left S_OUT while output register busy");
`endif

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Six-axis moving average testbench
// Streams force and torque samples through the boxcar filter, changes the
// window length and the enable between phases, and checks every average beat
// field by field against a cycle-free prediction of the window and its sums.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned SAMPLE_W       = 32;
  localparam int unsigned DEPTH          = 64;
  localparam int unsigned DATA_W         = ((sma_pkg::CHANNELS*SAMPLE_W+7)/8)*8;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES  = 300;
  localparam int unsigned PHASE_BEATS    = 150;
  localparam int unsigned PHASES         = 8;
  localparam int unsigned PHASE_LENGTHS [PHASES] = '{1, 64, 127, 2, 10, 37, 63, 5};

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef logic [sma_pkg::CHANNELS-1:0][SAMPLE_W-1:0] channels_t;

  typedef struct packed {
    logic      rejected;
    channels_t sample;
  } ft_beat_t;

  typedef enum int unsigned {RUN_FULL, RUN_MAX, RUN_MIN, RUN_SMALL} run_style_e;

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           cfg_we_i      = 1'b0;
  logic [sma_pkg::CFG_IDX_W-1:0]  cfg_idx_i     = sma_pkg::REG_ENABLED;
  logic [sma_pkg::CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [DATA_W-1:0]              s_axis_tdata  = '0;
  logic                           s_axis_tuser  = 1'b0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [DATA_W-1:0]              m_axis_tdata;

  string chan_name [sma_pkg::CHANNELS] = '{"avg_force_x", "avg_force_y", "avg_force_z",
                                           "avg_torque_x", "avg_torque_y", "avg_torque_z"};

  // Window state as the block should hold it
  logic signed [SAMPLE_W-1:0] win_ring [DEPTH][sma_pkg::CHANNELS];
  longint                     win_sum [sma_pkg::CHANNELS];
  int unsigned                win_pos;
  int unsigned                win_len;
  bit                         sensor_on;

  ft_beat_t    pending_samples [$];
  channels_t   expected_avgs [$];
  ft_beat_t    beat_on_bus;
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned fail_count     = 0;
  int unsigned quiet_cycles   = 0;

  six_axis_moving_average #(
    .MAX_DEPTH    (DEPTH),
    .SAMPLE_WIDTH (SAMPLE_W)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void clear_window();
    for (int d = 0; d < DEPTH; d++) begin
      for (int c = 0; c < sma_pkg::CHANNELS; c++) begin
        win_ring[d][c] = '0;
      end
    end
    for (int c = 0; c < sma_pkg::CHANNELS; c++) begin
      win_sum[c] = 0;
    end
    win_pos = 0;
  endfunction

  function automatic void apply_reg(logic [sma_pkg::CFG_IDX_W-1:0] idx,
                                    logic [sma_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      sma_pkg::REG_ENABLED: begin
        sensor_on = val[0];
      end
      sma_pkg::REG_HISTORY_LENGTH: begin
        // drop the write while powered or when zero; saturate above the depth
        if (!sensor_on && val != 0) begin
          win_len = (val > DEPTH) ? DEPTH : val;
          clear_window();
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic channels_t predict_averages(ft_beat_t b);
    channels_t avg;
    longint    q;
    if (sensor_on && !b.rejected) begin
      for (int c = 0; c < sma_pkg::CHANNELS; c++) begin
        win_sum[c] = win_sum[c] - win_ring[win_pos][c] + longint'($signed(b.sample[c]));
        win_ring[win_pos][c] = b.sample[c];
      end
      win_pos = (win_pos + 1 >= win_len) ? 0 : win_pos + 1;
    end
    for (int c = 0; c < sma_pkg::CHANNELS; c++) begin
      // signed division truncates toward zero
      q = win_sum[c] / longint'(win_len);
      avg[c] = q[SAMPLE_W-1:0];
    end
    return avg;
  endfunction

  function automatic void queue_beat(logic rejected, logic [SAMPLE_W-1:0] value);
    ft_beat_t b;
    b.rejected = rejected;
    for (int c = 0; c < sma_pkg::CHANNELS; c++) begin
      b.sample[c] = value;
    end
    pending_samples.push_back(b);
  endfunction

  // Runs of one style fill the window with extremes or small values now and then
  function automatic void queue_random(int unsigned count);
    int unsigned run_left;
    run_style_e  style;
    ft_beat_t    b;
    run_left = 0;
    style    = RUN_FULL;
    for (int i = 0; i < count; i++) begin
      if (run_left == 0) begin
        style    = ($urandom_range(5) > 3) ? RUN_FULL : run_style_e'($urandom_range(3));
        run_left = $urandom_range(80, 1);
      end
      run_left--;
      b.rejected = ($urandom_range(7) == 0);
      for (int c = 0; c < sma_pkg::CHANNELS; c++) begin
        case (style)
          RUN_MAX:   b.sample[c] = SAMPLE_MAX;
          RUN_MIN:   b.sample[c] = SAMPLE_MIN;
          RUN_SMALL: b.sample[c] = SAMPLE_W'($urandom_range(64) - 32);
          default:   b.sample[c] = SAMPLE_W'($urandom);
        endcase
      end
      pending_samples.push_back(b);
    end
  endfunction

  task automatic write_reg(logic [sma_pkg::CFG_IDX_W-1:0] idx,
                           logic [sma_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    apply_reg(idx, val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Hold until every queued sample is in and every average beat is back
  task automatic wait_drained();
    while (pending_samples.size() != 0 || s_axis_tvalid || expected_avgs.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Sample driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_avgs.push_back(predict_averages(beat_on_bus));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          beat_on_bus   = pending_samples.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= DATA_W'(beat_on_bus.sample);
          s_axis_tuser  <= beat_on_bus.rejected;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Average monitor
  always @(posedge clk_i) begin
    channels_t            want;
    logic [SAMPLE_W-1:0]  got;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_avgs.size() == 0) begin
          $error("average beat with none expected: %h", m_axis_tdata);
          fail_count++;
        end else begin
          want = expected_avgs.pop_front();
          for (int c = 0; c < sma_pkg::CHANNELS; c++) begin
            got = m_axis_tdata[c*SAMPLE_W +: SAMPLE_W];
            if (got !== want[c]) begin
              $error("%s: expected %0d, got %0d", chan_name[c], $signed(want[c]),
                     $signed(got));
              fail_count++;
            end
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Watchdog on handshake activity
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("six_axis_moving_average verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clear_window();
    win_len   = sma_pkg::DEFAULT_LENGTH;
    sensor_on = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Powered down after reset: averages stay at zero
    queue_beat(1'b0, SAMPLE_MAX);
    queue_beat(1'b1, SAMPLE_MIN);
    wait_drained();

    // Default window length, extremes, a rejected step, truncation of negatives
    write_reg(sma_pkg::REG_ENABLED, 7'h01);
    queue_beat(1'b0, SAMPLE_MAX);
    queue_beat(1'b0, SAMPLE_MAX);
    queue_beat(1'b0, SAMPLE_MIN);
    queue_beat(1'b0, -32'sd7);
    queue_beat(1'b1, 32'd123);
    queue_beat(1'b0, 32'd7);
    wait_drained();

    // Length write while powered is dropped
    write_reg(sma_pkg::REG_HISTORY_LENGTH, 7'd40);
    queue_beat(1'b0, 32'd1000);
    wait_drained();

    // Zero length dropped, then a window of one
    write_reg(sma_pkg::REG_ENABLED, 7'h7E);
    write_reg(sma_pkg::REG_HISTORY_LENGTH, 7'd0);
    write_reg(sma_pkg::REG_HISTORY_LENGTH, 7'd1);
    write_reg(sma_pkg::REG_ENABLED, 7'h7F);
    queue_beat(1'b0, SAMPLE_MAX);
    queue_beat(1'b0, SAMPLE_MIN);
    queue_beat(1'b0, 32'h0001_0000);
    queue_beat(1'b1, SAMPLE_MAX);
    wait_drained();

    // Oversized length saturates to the full depth
    write_reg(sma_pkg::REG_ENABLED, 7'h00);
    write_reg(sma_pkg::REG_HISTORY_LENGTH, 7'd127);
    write_reg(sma_pkg::REG_ENABLED, 7'h01);
    queue_beat(1'b0, -32'sd7);
    queue_beat(1'b0, -32'sd7);
    queue_beat(1'b0, -32'sd7);
    queue_beat(1'b0, SAMPLE_MIN);
    queue_beat(1'b0, SAMPLE_MIN);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      write_reg(sma_pkg::REG_ENABLED,
                sma_pkg::CFG_DATA_W'($urandom) & ~sma_pkg::CFG_DATA_W'(1));
      write_reg(sma_pkg::REG_HISTORY_LENGTH,
                (p == PHASES - 1) ? sma_pkg::CFG_DATA_W'($urandom_range(63, 2))
                                  : sma_pkg::CFG_DATA_W'(PHASE_LENGTHS[p]));
      if (p == 3) begin
        queue_random(6);
        wait_drained();
      end
      write_reg(sma_pkg::REG_ENABLED,
                sma_pkg::CFG_DATA_W'($urandom) | sma_pkg::CFG_DATA_W'(1));
      if (p % 2 == 1) begin
        write_reg(sma_pkg::REG_HISTORY_LENGTH,
                  sma_pkg::CFG_DATA_W'($urandom_range(127, 1)));
      end
      case (p % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 65; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 65; end
        default: begin src_idle_pct = 16; sink_stall_pct = 16; end
      endcase
      queue_random(PHASE_BEATS);
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("six_axis_moving_average verification clean");
    end else begin
      $display("six_axis_moving_average verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
src/sma_pkg.sv
src/sma_front.sv
src/sma_div.sv
src/sma_back.sv
src/six_axis_moving_average.sv
dv/tb_top.sv
